// ===== src/lobm_pkg.sv =====
// package of shared types and constants for the order book matcher
package lobm_pkg;
   localparam int OrderSlots = 32;
   localparam int SlotBits = $clog2(OrderSlots);
   localparam int MaxFills = 32;
   localparam int FillBits = $clog2(MaxFills + 1);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_MATCH = 2'd2;
   localparam logic [1:0] OP_IGNORED = 2'd3;

   localparam logic [2:0] KIND_ADDED = 3'd0;
   localparam logic [2:0] KIND_FULL = 3'd1;
   localparam logic [2:0] KIND_DUP = 3'd2;
   localparam logic [2:0] KIND_CANCELLED = 3'd3;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
   localparam logic [2:0] KIND_FILL = 3'd5;
   localparam logic [2:0] KIND_DONE = 3'd6;

   typedef struct packed {
      logic [1:0] operation;
      logic side;
      logic [31:0] order_id;
      logic [31:0] price_ticks;
      logic [30:0] quantity;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [31:0] resting_id;
      logic [31:0] fill_price_ticks;
      logic [30:0] executed_qty;
      logic [30:0] resting_left;
      logic [30:0] unfilled_qty;
      logic last;
   } rsp_type;
endpackage

// ===== src/lobm_req_if.sv =====
// valid/ready channel carrying one request
interface lobm_req_if;
   logic valid;
   logic ready;
   lobm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/lobm_rsp_if.sv =====
// valid/ready channel carrying one result
interface lobm_rsp_if;
   logic valid;
   logic ready;
   lobm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/limit_order_book_matcher.sv =====
// order book matcher top level with slot scan sequencer
// requests come in on req (add, cancel, match) and results leave on rsp.
// one request is taken at a time; req_ready is low while it is worked.
// a single slot compare unit visits one slot per cycle, so add, cancel
// and match requests scan all slots (a match of zero quantity does not).
// a match repeats one scan of all slots per fill and sends each fill as
// it is found, then a done item with last set.
// results sit in one output register; while the receiver stalls the
// sequencer waits and nothing is lost or repeated.
// reset (synchronous, active high) empties the book and clears the
// arrival counter; slot contents other than valid bits are not cleared.
// req_ready stays low while reset is high.
// unknown operation codes are taken and dropped with no result.
module limit_order_book_matcher (
   input logic clock,
   input logic reset,
   lobm_req_if.sink req,
   lobm_rsp_if.source rsp
);
   localparam int N = lobm_pkg::OrderSlots;
   localparam int SB = lobm_pkg::SlotBits;

   typedef enum logic [2:0] {IDLE, SCAN, DECIDE, SEND, SEND_DONE} state_type;

   state_type state_ff;
   logic [N-1:0] valid_ff;
   logic side_mem [N];
   logic [31:0] id_mem [N];
   logic [31:0] price_mem [N];
   logic [30:0] qty_mem [N];
   logic [31:0] arr_mem [N];
   logic [31:0] arrival_ff;

   lobm_pkg::req_type cur_ff;
   logic [30:0] remain_ff;
   logic [lobm_pkg::FillBits-1:0] fills_ff;
   logic [SB-1:0] idx_ff;
   logic found_ff;
   logic [SB-1:0] best_ff;
   logic [31:0] best_price_ff;
   logic [31:0] best_age_ff;
   logic have_free_ff;
   logic [SB-1:0] free_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   lobm_pkg::rsp_type rsp_ff;
   lobm_pkg::rsp_type rsp_in;

   logic [SB-1:0] idx;
   logic book;
   logic [31:0] age;
   logic better;
   logic [30:0] exec_q;
   logic [30:0] left_q;
   logic outside;
   logic rsp_free;
   logic rsp_load;

   assign idx = idx_ff;
   assign book = ~cur_ff.side;
   assign age = arrival_ff - arr_mem[idx];
   always_comb begin
      if (!found_ff) begin
         better = 1'b1;
      end else if (price_mem[idx] != best_price_ff) begin
         better = book ? (price_mem[idx] < best_price_ff) : (price_mem[idx] > best_price_ff);
      end else begin
         better = age > best_age_ff;
      end
   end
   assign exec_q = (qty_mem[best_ff] < remain_ff) ? qty_mem[best_ff] : remain_ff;
   assign left_q = qty_mem[best_ff] - exec_q;
   assign outside = (cur_ff.price_ticks != 32'd0) &&
      (book ? (best_price_ff > cur_ff.price_ticks) : (best_price_ff < cur_ff.price_ticks));

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign rsp_load = rsp_free && (state_ff == DECIDE || state_ff == SEND_DONE);

   // result to be loaded into the output register
   always_comb begin
      rsp_in = '0;
      rsp_in.last = 1'b1;
      rsp_in.resting_id = cur_ff.order_id;
      if (state_ff == SEND_DONE) begin
         rsp_in.kind = lobm_pkg::KIND_DONE;
         rsp_in.resting_id = '0;
         rsp_in.unfilled_qty = remain_ff;
      end else begin
         case (cur_ff.operation)
            lobm_pkg::OP_ADD: begin
               if (found_ff) begin
                  rsp_in.kind = lobm_pkg::KIND_DUP;
               end else if (!have_free_ff) begin
                  rsp_in.kind = lobm_pkg::KIND_FULL;
               end else begin
                  rsp_in.kind = lobm_pkg::KIND_ADDED;
                  rsp_in.fill_price_ticks = cur_ff.price_ticks;
                  rsp_in.resting_left = cur_ff.quantity;
               end
            end
            lobm_pkg::OP_CANCEL: begin
               if (found_ff) begin
                  rsp_in.kind = lobm_pkg::KIND_CANCELLED;
                  rsp_in.fill_price_ticks = price_mem[best_ff];
                  rsp_in.resting_left = qty_mem[best_ff];
               end else begin
                  rsp_in.kind = lobm_pkg::KIND_NOT_FOUND;
               end
            end
            default: begin
               rsp_in.kind = lobm_pkg::KIND_FILL;
               rsp_in.last = 1'b0;
               rsp_in.resting_id = id_mem[best_ff];
               rsp_in.fill_price_ticks = best_price_ff;
               rsp_in.executed_qty = exec_q;
               rsp_in.resting_left = left_q;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (rsp_load && (state_ff == SEND_DONE || cur_ff.operation != lobm_pkg::OP_MATCH ||
                       (found_ff && !outside))) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req.ready = (state_ff == IDLE) && !reset;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= '0;
         arrival_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (rsp_load) begin
            rsp_ff <= rsp_in;
         end
         case (state_ff)
            IDLE: begin
               if (req.valid) begin
                  cur_ff <= req.data;
                  remain_ff <= req.data.quantity;
                  fills_ff <= '0;
                  idx_ff <= '0;
                  found_ff <= 1'b0;
                  have_free_ff <= 1'b0;
                  if (req.data.operation == lobm_pkg::OP_MATCH &&
                      req.data.quantity == 31'd0) begin
                     state_ff <= SEND_DONE;
                  end else if (req.data.operation == lobm_pkg::OP_ADD ||
                               req.data.operation == lobm_pkg::OP_CANCEL ||
                               req.data.operation == lobm_pkg::OP_MATCH) begin
                     state_ff <= SCAN;
                  end
               end
            end
            SCAN: begin
               if (cur_ff.operation == lobm_pkg::OP_MATCH) begin
                  if (valid_ff[idx] && side_mem[idx] == book && qty_mem[idx] != 31'd0 &&
                      better) begin
                     found_ff <= 1'b1;
                     best_ff <= idx;
                     best_price_ff <= price_mem[idx];
                     best_age_ff <= age;
                  end
               end else begin
                  if (valid_ff[idx] && id_mem[idx] == cur_ff.order_id && !found_ff) begin
                     found_ff <= 1'b1;
                     best_ff <= idx;
                  end
                  if (!valid_ff[idx] && !have_free_ff) begin
                     have_free_ff <= 1'b1;
                     free_ff <= idx;
                  end
               end
               if (idx_ff == SB'(N-1)) begin
                  state_ff <= DECIDE;
               end
               idx_ff <= idx_ff + SB'(1);
            end
            DECIDE: begin
               if (rsp_free) begin
                  case (cur_ff.operation)
                     lobm_pkg::OP_ADD: begin
                        state_ff <= IDLE;
                        if (!found_ff && have_free_ff) begin
                           valid_ff[free_ff] <= 1'b1;
                           side_mem[free_ff] <= cur_ff.side;
                           id_mem[free_ff] <= cur_ff.order_id;
                           price_mem[free_ff] <= cur_ff.price_ticks;
                           qty_mem[free_ff] <= cur_ff.quantity;
                           arr_mem[free_ff] <= arrival_ff;
                           arrival_ff <= arrival_ff + 32'd1;
                        end
                     end
                     lobm_pkg::OP_CANCEL: begin
                        state_ff <= IDLE;
                        if (found_ff) begin
                           valid_ff[best_ff] <= 1'b0;
                        end
                     end
                     default: begin
                        if (found_ff && !outside) begin
                           qty_mem[best_ff] <= left_q;
                           if (left_q == 31'd0) begin
                              valid_ff[best_ff] <= 1'b0;
                           end
                           remain_ff <= remain_ff - exec_q;
                           fills_ff <= fills_ff + lobm_pkg::FillBits'(1);
                           state_ff <= SEND;
                        end else begin
                           state_ff <= SEND_DONE;
                        end
                     end
                  endcase
               end
            end
            SEND: begin
               idx_ff <= '0;
               found_ff <= 1'b0;
               if (remain_ff == 31'd0 ||
                   fills_ff == lobm_pkg::FillBits'(lobm_pkg::MaxFills)) begin
                  state_ff <= SEND_DONE;
               end else begin
                  state_ff <= SCAN;
               end
            end
            SEND_DONE: begin
               if (rsp_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// ===== src/lobm_checker.sv =====
// port checker for the order book matcher, bound to the top level
module lobm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input lobm_pkg::req_type req_data,
   input logic rsp_valid,
   input logic rsp_ready,
   input lobm_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kind <= lobm_pkg::KIND_DONE)
      else $error("bad result kind");
   a_fill_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == lobm_pkg::KIND_FILL |-> !rsp_data.last)
      else $error("fill flagged last");
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation != lobm_pkg::OP_IGNORED |=> !req_ready)
      else $error("ready right after transfer");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .req_data(req.data),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_data(rsp.data)
);
